// ----- rtl/ngzp_pkg.sv -----
package ngzp_pkg;
    localparam int unsigned MAX_YEAR = 9999;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_OUT  = 3'd2;
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_ZDA   = 2'd2;

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd2: r = 9'd31;
                4'd3: r = 9'd59;
                4'd4: r = 9'd90;
                4'd5: r = 9'd120;
                4'd6: r = 9'd151;
                4'd7: r = 9'd181;
                4'd8: r = 9'd212;
                4'd9: r = 9'd243;
                4'd10: r = 9'd273;
                4'd11: r = 9'd304;
                4'd12: r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction
endpackage

// ----- rtl/nmea_gga_zda_sentence_parser.sv -----
// channel | signals                                   | dir
// in      | char_byte, end_of_sentence, valid/ready   | in
// out     | sentence_kind .. utc_second, valid/ready  | out
// A byte that does not end a sentence is taken without leaving the idle state.
// On the final byte of a ZDA sentence whose date fields pass, a sequencer runs one
// shared 24x24 multiply-add/subtract step by step (time split, leap test, days, seconds);
// other final bytes go straight to the result. The result is held until taken and
// no byte is taken meanwhile.
// rst_n asynchronously clears all state.
module nmea_gga_zda_sentence_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_byte,
    input  logic        end_of_sentence,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [1:0]  sentence_kind,
    output logic        checksum_ok,
    output logic        has_fix,
    output logic        time_valid,
    output logic [37:0] utc_second,
    output logic        out_valid,
    input  logic        out_ready
);
    logic [2:0]  state_reg;
    logic [7:0]  ck_reg;
    logic [2:0]  pos_reg;
    logic        lead_reg, star_reg, open_reg;
    logic [1:0]  hexc_reg;
    logic [7:0]  hexv_reg;
    logic [23:0] type_reg;
    logic [2:0]  comma_reg;
    logic [1:0]  qual_reg, tps_reg;
    logic [19:0] tacc_reg;
    logic [6:0]  day_reg, mon_reg;
    logic [13:0] year_reg;
    logic [3:0]  step_reg;
    logic [37:0] acc_reg;
    logic [19:0] rem_reg;
    logic [6:0]  hh_reg;
    logic [6:0]  mm_reg, ss_reg;
    logic [7:0]  q1_reg, q2_reg;

    logic        acc_in;
    logic        digit;
    logic [3:0]  dval;
    logic [4:0]  hexd;

    assign in_ready = (state_reg == ngzp_pkg::ST_IDLE);
    assign acc_in = in_valid && in_ready;
    assign out_valid = (state_reg == ngzp_pkg::ST_OUT);
    assign digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    assign dval = 4'(char_byte - 8'h30);

    always_comb
    begin
        if (digit) hexd = {1'b0, dval};
        else if (char_byte >= 8'h41 && char_byte <= 8'h46) hexd = 5'(char_byte - 8'h37);
        else if (char_byte >= 8'h61 && char_byte <= 8'h66) hexd = 5'(char_byte - 8'h57);
        else hexd = 5'd16;
    end

    // parse-time values of the sentence including the current byte
    logic [7:0]  n_ck, n_hexv;
    logic [2:0]  n_pos, n_comma;
    logic        n_lead, n_star, n_open;
    logic [1:0]  n_hexc, n_qual, n_tps;
    logic [23:0] n_type;
    logic [19:0] n_tacc;
    logic [6:0]  n_day, n_mon;
    logic [13:0] n_year;
    logic [23:0] t10;
    logic [10:0] d10;
    logic [17:0] y10;

    always_comb
    begin
        n_ck = ck_reg; n_hexv = hexv_reg; n_pos = pos_reg; n_comma = comma_reg;
        n_lead = lead_reg; n_star = star_reg; n_open = open_reg; n_hexc = hexc_reg;
        n_qual = qual_reg; n_tps = tps_reg; n_type = type_reg; n_tacc = tacc_reg;
        n_day = day_reg; n_mon = mon_reg; n_year = year_reg;
        t10 = 24'(tacc_reg) * 24'd10 + 24'(dval);
        d10 = 11'(comma_reg == 3'd2 ? day_reg : mon_reg) * 11'd10 + 11'(dval);
        y10 = 18'(year_reg) * 18'd10 + 18'(dval);
        if (pos_reg == 3'd0) n_lead = (char_byte == 8'h24);
        if (pos_reg >= 3'd3 && pos_reg <= 3'd5) n_type = {type_reg[15:0], char_byte};
        if (!star_reg) begin
            if (char_byte == 8'h2A) n_star = 1'b1;
            else if (pos_reg >= 3'd1) n_ck = ck_reg ^ char_byte;
        end else if (hexc_reg < 2'd2) begin
            if (!hexd[4]) begin
                n_hexv = {hexv_reg[3:0], hexd[3:0]};
                n_hexc = hexc_reg + 2'd1;
            end else n_hexc = 2'd3;
        end
        if (comma_reg == 3'd6) begin
            if (qual_reg == 2'd0)
                n_qual = (char_byte >= 8'h31 && char_byte <= 8'h39) ? 2'd1 : 2'd3;
            else if (qual_reg == 2'd1)
                n_qual = (char_byte == 8'h2C || char_byte == 8'h2A) ? 2'd2 : 2'd3;
        end
        if (comma_reg == 3'd1 && tps_reg != 2'd3) begin
            if (digit) begin
                if (tps_reg == 2'd0 || tps_reg == 2'd1) begin
                    n_tps = 2'd1;
                    n_tacc = (t10 > 24'hFFFFF) ? 20'hFFFFF : t10[19:0];
                end
            end else if (char_byte == 8'h2E) n_tps = (tps_reg == 2'd1) ? 2'd2 : 2'd3;
            else if (char_byte == 8'h2C) begin
                if (tps_reg == 2'd0) n_tps = 2'd3;
            end else n_tps = 2'd3;
        end
        if (comma_reg >= 3'd2 && comma_reg <= 3'd4 && open_reg) begin
            if (!digit) n_open = 1'b0;
            else if (comma_reg == 3'd2) n_day = (d10 > 11'd127) ? 7'd127 : d10[6:0];
            else if (comma_reg == 3'd3) n_mon = (d10 > 11'd127) ? 7'd127 : d10[6:0];
            else n_year = (y10 > 18'd16383) ? 14'd16383 : y10[13:0];
        end
        if (char_byte == 8'h2C) begin
            if (comma_reg < 3'd7) n_comma = comma_reg + 3'd1;
            n_open = 1'b1;
        end
        if (pos_reg < 3'd7) n_pos = pos_reg + 3'd1;
    end

    logic       ck, ok_zda, leap, rng, tm_ok;
    logic [1:0] kind;
    assign ck = n_lead && n_star && (n_hexc == 2'd2) && (n_hexv == n_ck);
    always_comb
    begin
        kind = ngzp_pkg::KIND_OTHER;
        if (ck && n_pos >= 3'd6) begin
            if (n_type == 24'h474741) kind = ngzp_pkg::KIND_GGA;
            else if (n_type == 24'h5A4441) kind = ngzp_pkg::KIND_ZDA;
        end
    end
    assign rng = (32'(n_year) >= 32'd1970) && (32'(n_year) <= ngzp_pkg::MAX_YEAR)
        && n_mon >= 7'd1 && n_mon <= 7'd12 && n_day >= 7'd1 && n_day <= 7'd31;
    assign ok_zda = (kind == ngzp_pkg::KIND_ZDA) && n_comma >= 3'd4
        && (n_tps == 2'd1 || n_tps == 2'd2) && rng;
    assign tm_ok = (hh_reg <= 7'd23) && (mm_reg <= 7'd59) && (ss_reg <= 7'd60);

    // shared unit: acc +/- a*b; divisions by 100 and 10000 by reciprocal multiply
    logic [23:0] mul_a, mul_b;
    logic        sub_op;
    logic [47:0] prod;
    logic [37:0] mac;
    assign prod = mul_a * mul_b;
    assign mac = sub_op ? acc_reg - prod[37:0] : acc_reg + prod[37:0];
    logic [13:0] ym1;
    assign ym1 = year_reg - 14'd1;
    always_comb
    begin
        mul_a = 24'd0; mul_b = 24'd0; sub_op = 1'b0;
        case (step_reg)
            4'd0: begin mul_a = 24'(rem_reg); mul_b = 24'd1717987; end
            4'd1: begin mul_a = 24'(hh_reg); mul_b = 24'd10000; end
            4'd2: begin mul_a = 24'(rem_reg[13:0]); mul_b = 24'd10486; end
            4'd3: begin mul_a = 24'(mm_reg); mul_b = 24'd100; end
            4'd4: begin mul_a = 24'(ym1); mul_b = 24'd10486; end
            4'd5: begin mul_a = 24'(year_reg); mul_b = 24'd10486; end
            4'd6: begin mul_a = 24'(ym1); mul_b = 24'd365; end
            4'd7: begin mul_a = 24'(ym1[13:2]); mul_b = 24'd1; end
            4'd8: begin mul_a = 24'(q1_reg); mul_b = 24'd1; sub_op = 1'b1; end
            4'd9: begin mul_a = 24'(q1_reg[7:2]); mul_b = 24'd1; end
            4'd10: begin mul_a = 24'd719162; mul_b = 24'd1; sub_op = 1'b1; end
            4'd11: begin
                mul_a = 24'(ngzp_pkg::days_before_month(mon_reg[3:0]))
                    + 24'(day_reg) - 24'd1 + 24'(leap && mon_reg > 7'd2);
                mul_b = 24'd1;
            end
            4'd12: begin mul_a = acc_reg[23:0]; mul_b = 24'd86399; end
            4'd13: begin mul_a = 24'(hh_reg); mul_b = 24'd3600; end
            4'd14: begin mul_a = 24'(mm_reg); mul_b = 24'd60; end
            4'd15: begin mul_a = 24'(ss_reg); mul_b = 24'd1; end
            default: begin mul_a = 24'd0; mul_b = 24'd0; end
        endcase
    end
    // year divisible by 100 when year/100 differs from (year-1)/100, same for 400
    assign leap = (year_reg[1:0] == 2'd0)
        && ((q2_reg == q1_reg) || (q2_reg[7:2] != q1_reg[7:2]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ngzp_pkg::ST_IDLE;
            ck_reg <= '0; pos_reg <= '0; lead_reg <= 1'b0; star_reg <= 1'b0;
            open_reg <= 1'b0; hexc_reg <= '0; hexv_reg <= '0; type_reg <= '0;
            comma_reg <= '0; qual_reg <= '0; tps_reg <= '0; tacc_reg <= '0;
            day_reg <= '0; mon_reg <= '0; year_reg <= '0; step_reg <= '0;
        end else begin
            case (state_reg)
                ngzp_pkg::ST_IDLE:
                begin
                    if (acc_in) begin
                        if (!end_of_sentence) begin
                            ck_reg <= n_ck; pos_reg <= n_pos; lead_reg <= n_lead;
                            star_reg <= n_star; open_reg <= n_open; hexc_reg <= n_hexc;
                            hexv_reg <= n_hexv; type_reg <= n_type; comma_reg <= n_comma;
                            qual_reg <= n_qual; tps_reg <= n_tps; tacc_reg <= n_tacc;
                            day_reg <= n_day; mon_reg <= n_mon; year_reg <= n_year;
                        end else begin
                            ck_reg <= '0; pos_reg <= '0; lead_reg <= 1'b0;
                            star_reg <= 1'b0; open_reg <= 1'b0; hexc_reg <= '0;
                            hexv_reg <= '0; type_reg <= '0; comma_reg <= '0;
                            qual_reg <= '0; tps_reg <= '0; tacc_reg <= '0;
                            day_reg <= n_day; mon_reg <= n_mon; year_reg <= n_year;
                            step_reg <= '0;
                            state_reg <= ok_zda ? ngzp_pkg::ST_CONV : ngzp_pkg::ST_OUT;
                        end
                    end
                end
                ngzp_pkg::ST_CONV:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15) state_reg <= ngzp_pkg::ST_OUT;
                end
                ngzp_pkg::ST_OUT:
                begin
                    if (out_ready) begin
                        state_reg <= ngzp_pkg::ST_IDLE;
                        day_reg <= '0; mon_reg <= '0; year_reg <= '0;
                    end
                end
                default: state_reg <= ngzp_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sentence_kind <= ngzp_pkg::KIND_OTHER;
            checksum_ok <= 1'b0;
            has_fix <= 1'b0;
            time_valid <= 1'b0;
            acc_reg <= '0;
            rem_reg <= '0;
            hh_reg <= '0;
            mm_reg <= '0;
            ss_reg <= '0;
            q1_reg <= '0;
            q2_reg <= '0;
        end else if (acc_in && end_of_sentence) begin
            sentence_kind <= kind;
            checksum_ok <= ck;
            has_fix <= (kind == ngzp_pkg::KIND_GGA) && (n_qual == 2'd2);
            time_valid <= ok_zda;
            acc_reg <= '0;
            rem_reg <= n_tacc;
        end else if (state_reg == ngzp_pkg::ST_CONV) begin
            case (step_reg)
                4'd0: hh_reg <= prod[40:34];
                4'd1: rem_reg <= rem_reg - prod[19:0];
                4'd2: mm_reg <= prod[26:20];
                4'd3: ss_reg <= rem_reg[6:0] - prod[6:0];
                4'd4: q1_reg <= prod[27:20];
                4'd5:
                begin
                    q2_reg <= prod[27:20];
                    time_valid <= time_valid && tm_ok;
                end
                default: acc_reg <= mac;
            endcase
        end
    end
    assign utc_second = time_valid ? acc_reg : 38'd0;
endmodule

// ----- verif/tb_nmea_gga_zda_sentence_parser.sv -----
`timescale 1ns / 1ps

module tb_nmea_gga_zda_sentence_parser;

    logic        clk;
    logic        rst_n;
    logic [7:0]  char_byte;
    logic        end_of_sentence;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  sentence_kind;
    logic        checksum_ok;
    logic        has_fix;
    logic        time_valid;
    logic [37:0] utc_second;
    logic        out_valid;
    logic        out_ready;

    nmea_gga_zda_sentence_parser dut (
        .clk(clk), .rst_n(rst_n), .char_byte(char_byte),
        .end_of_sentence(end_of_sentence), .in_valid(in_valid), .in_ready(in_ready),
        .sentence_kind(sentence_kind), .checksum_ok(checksum_ok), .has_fix(has_fix),
        .time_valid(time_valid), .utc_second(utc_second), .out_valid(out_valid),
        .out_ready(out_ready)
    );

    typedef struct packed {
        logic [1:0]  kind;
        logic        ck;
        logic        fix;
        logic        tv;
        logic [37:0] secs;
    } report_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       has_exp;
        report_t    exp;
    } row_t;

    report_t report_q[$];
    byte     stim_b[$];
    bit      stim_last[$];
    int      fails;
    int      mism;
    bit      stim_done;
    bit      hold_active;
    int      hold_count;
    int      quiet_start;
    int      cyc;

    // parser model state
    logic [7:0]  p_xor;
    logic [2:0]  p_pos;
    logic        p_lead;
    logic        p_star;
    logic [1:0]  p_hexn;
    logic [7:0]  p_hexv;
    logic [23:0] p_type;
    logic [2:0]  p_commas;
    logic [1:0]  p_qual;
    logic [19:0] p_time;
    logic [1:0]  p_tstate;
    logic [6:0]  p_day;
    logic [6:0]  p_mon;
    logic [13:0] p_year;
    logic        p_open;

    function automatic longint unsigned sat_digit(longint unsigned acc, int d,
                                                  longint unsigned cap);
        longint unsigned v;
        v = acc * 10 + d;
        return (v > cap) ? cap : v;
    endfunction

    function automatic longint unsigned days_upto(longint unsigned yr);
        longint unsigned y;
        y = yr - 1;
        return 365 * y + y / 4 - y / 100 + y / 400;
    endfunction

    function automatic int month_offset(int m);
        int t[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        return t[m];
    endfunction

    task automatic parser_clear();
        p_xor = 0; p_pos = 0; p_lead = 0; p_star = 0; p_hexn = 0; p_hexv = 0;
        p_type = 0; p_commas = 0; p_qual = 0; p_time = 0; p_tstate = 0;
        p_day = 0; p_mon = 0; p_year = 0; p_open = 0;
    endtask

    task automatic parse_byte(input logic [7:0] c, input logic last, output bit got,
                              output report_t r);
        bit dig;
        int hd;
        bit ck;
        int hh, mm, ss, d, m, y;
        longint unsigned days, secs;
        dig = (c >= "0" && c <= "9");
        got = 0;
        r = '0;
        if (p_pos == 0) p_lead = (c == "$");
        if (p_pos >= 3 && p_pos <= 5) p_type = {p_type[15:0], c};
        if (!p_star) begin
            if (c == "*") p_star = 1;
            else if (p_pos >= 1) p_xor ^= c;
        end
        else if (p_hexn < 2) begin
            if (dig) hd = c - "0";
            else if (c >= "A" && c <= "F") hd = c - "A" + 10;
            else if (c >= "a" && c <= "f") hd = c - "a" + 10;
            else hd = 16;
            if (hd < 16) begin
                p_hexv = {p_hexv[3:0], 4'(hd)};
                p_hexn++;
            end
            else p_hexn = 3;
        end
        if (p_commas == 6) begin
            if (p_qual == 0) p_qual = (c >= "1" && c <= "9") ? 2'd1 : 2'd3;
            else if (p_qual == 1) p_qual = (c == "," || c == "*") ? 2'd2 : 2'd3;
        end
        if (p_commas == 1 && p_tstate != 3) begin
            if (dig) begin
                if (p_tstate == 0) p_tstate = 1;
                if (p_tstate == 1) p_time = 20'(sat_digit(p_time, c - "0", 20'hFFFFF));
            end
            else if (c == ".") p_tstate = (p_tstate == 1) ? 2'd2 : 2'd3;
            else if (c == ",") begin
                if (p_tstate == 0) p_tstate = 3;
            end
            else p_tstate = 3;
        end
        if (p_commas >= 2 && p_commas <= 4 && p_open) begin
            if (!dig) p_open = 0;
            else if (p_commas == 2) p_day = 7'(sat_digit(p_day, c - "0", 127));
            else if (p_commas == 3) p_mon = 7'(sat_digit(p_mon, c - "0", 127));
            else p_year = 14'(sat_digit(p_year, c - "0", 16383));
        end
        if (c == ",") begin
            if (p_commas < 7) p_commas++;
            p_open = 1;
        end
        if (p_pos < 7) p_pos++;
        if (last) begin
            got = 1;
            ck = p_lead && p_star && p_hexn == 2 && p_hexv == p_xor;
            if (ck && p_pos >= 6) begin
                if (p_type == 24'h474741) r.kind = ngzp_pkg::KIND_GGA;
                else if (p_type == 24'h5A4441) r.kind = ngzp_pkg::KIND_ZDA;
            end
            r.ck = ck;
            if (r.kind == ngzp_pkg::KIND_GGA) r.fix = (p_qual == 2);
            if (r.kind == ngzp_pkg::KIND_ZDA && p_commas >= 4
                && (p_tstate == 1 || p_tstate == 2))
            begin
                hh = p_time / 10000; mm = (p_time / 100) % 100; ss = p_time % 100;
                d = p_day; m = p_mon; y = p_year;
                if (y >= 1970 && y <= ngzp_pkg::MAX_YEAR && m >= 1 && m <= 12
                    && d >= 1 && d <= 31 && hh <= 23 && mm <= 59 && ss <= 60) begin
                    days = days_upto(y) - days_upto(1970) + month_offset(m) + d - 1;
                    if (m > 2 && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0)))
                        days++;
                    secs = days * 86400 + hh * 3600 + mm * 60 + ss;
                    r.secs = secs[37:0];
                    r.tv = 1;
                end
            end
            parser_clear();
        end
    endtask

    // sentence building
    function automatic string hex2(logic [7:0] v);
        return $sformatf("%02X", v);
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            stim_b.push_back(s[i]);
            stim_last.push_back(i == s.len() - 1);
        end
    endtask

    function automatic string framed(string body, bit bad_ck, bit lower);
        logic [7:0] x;
        string h;
        x = 0;
        for (int i = 0; i < body.len(); i++) x ^= body[i];
        if (bad_ck) x ^= 8'(1 << $urandom_range(0, 7));
        h = lower ? $sformatf("%02x", x) : hex2(x);
        return {"$", body, "*", h};
    endfunction

    function automatic string rnd_digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    function automatic string rnd_zda();
        string t, s;
        int yr;
        if ($urandom_range(0, 9) == 0) t = rnd_digits($urandom_range(0, 8));
        else t = $sformatf("%02d%02d%02d", $urandom_range(0, 25), $urandom_range(0, 62),
                           $urandom_range(0, 61));
        if ($urandom_range(0, 2) == 0) t = {t, ".", rnd_digits($urandom_range(0, 3))};
        if ($urandom_range(0, 3) == 0) yr = $urandom_range(0, 16383);
        else if ($urandom_range(0, 4) == 0) yr = 9999;
        else yr = $urandom_range(1970, 2200);
        s = $sformatf("GPZDA,%s,%0d,%0d,%0d,00,00", t, $urandom_range(0, 33),
                      $urandom_range(0, 13), yr);
        if ($urandom_range(0, 15) == 0) s = {s, rnd_digits(3)};
        return s;
    endfunction

    function automatic string rnd_gga();
        string q;
        case ($urandom_range(0, 5))
            0: q = "";
            1: q = "0";
            2: q = rnd_digits(2);
            3: q = "x";
            default: q = $sformatf("%0d", $urandom_range(1, 9));
        endcase
        return $sformatf("GPGGA,%s,4807.038,N,01131.000,E,%s,08,0.9", rnd_digits(6), q);
    endfunction

    task automatic push_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            stim_b.push_back(8'($urandom_range(0, 255)));
            stim_last.push_back(i == n - 1);
        end
    endtask

    row_t table_rows[$];

    task automatic add_raw(input logic [7:0] b, input bit last, input bit has_exp,
                           input report_t e);
        row_t r;
        r.b = b;
        r.last = last;
        r.has_exp = has_exp && last;
        r.exp = e;
        table_rows.push_back(r);
    endtask

    task automatic add_rows(input string s, input bit has_exp, input report_t e);
        for (int i = 0; i < s.len(); i++)
            add_raw(s[i], i == s.len() - 1, has_exp, e);
    endtask

    initial clk = 0;

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    initial
    begin
        #5000000;
        $display("nmea_gga_zda_sentence_parser verification failed");
        $finish;
    end

    // sender
    initial
    begin
        report_t e, none;
        bit got;
        int k;
        rst_n = 0;
        in_valid = 0;
        char_byte = 0;
        end_of_sentence = 0;
        stim_done = 0;
        fails = 0;
        mism = 0;
        parser_clear();
        none = '0;
        // epoch, upper limit, leap day, min byte, max byte, short, bad lead
        e = '0; e.kind = ngzp_pkg::KIND_ZDA; e.ck = 1; e.tv = 1; e.secs = 0;
        add_rows(framed("GPZDA,000000,01,01,1970", 0, 0), 1, e);
        e.secs = 38'd253402300799;
        add_rows(framed("GPZDA,235959.99,31,12,9999", 0, 1), 1, e);
        e.secs = 38'd951782400;
        add_rows(framed("GPZDA,000000,29,02,2000,00,00", 0, 0), 1, e);
        add_rows(framed("GPZDA,240000,01,01,2000", 0, 0), 0, none);
        add_rows(framed("GPZDA,.5,01,01,2000", 0, 0), 0, none);
        e = '0; e.kind = ngzp_pkg::KIND_GGA; e.ck = 1; e.fix = 1;
        add_rows(framed("GPGGA,1,2,3,4,5,9*", 0, 0), 0, none);
        add_rows(framed("GPGGA,123519,4807.038,N,01131.000,E,1,08", 0, 0), 1, e);
        add_rows(framed("GPGGA,123519,,,,,10,08", 0, 0), 0, none);
        add_rows(framed("GPZDA,000000,01,01,1970", 1, 0), 0, none);
        add_rows("x", 1, none);
        add_raw(8'h00, 0, 0, none);
        add_raw(8'hFF, 1, 1, none);
        add_rows("$*00", 0, none);
        add_rows(framed("GPRMC,1,2", 0, 0), 0, none);
        add_rows(framed("GPZDA,999999999,999,999,99999", 0, 0), 0, none);
        repeat (3) @(posedge clk);
        rst_n <= 1;
        foreach (table_rows[i])
        begin
            stim_b.push_back(table_rows[i].b);
            stim_last.push_back(table_rows[i].last);
        end
        while (stim_b.size() < 1850)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_str(framed(rnd_zda(), $urandom_range(0, 9) == 0,
                                          $urandom_range(0, 1)));
                4, 5, 6: push_str(framed(rnd_gga(), $urandom_range(0, 9) == 0, 0));
                7: push_noise();
                default: push_str(framed($sformatf("GP%s,1,2", rnd_digits(3)), 0, 0));
            endcase
        end
        k = 0;
        while (stim_b.size() > 0)
        begin
            @(posedge clk);
            if (!(in_valid && !in_ready)) begin
                if (cyc < quiet_start || cyc > quiet_start + 400 ?
                    $urandom_range(0, 99) >= 22 : 1) begin
                    char_byte <= stim_b[0];
                    end_of_sentence <= stim_last[0];
                    in_valid <= 1;
                    parse_byte(stim_b[0], stim_last[0], got, e);
                    if (k < table_rows.size() && table_rows[k].has_exp
                        && e != table_rows[k].exp)
                    begin
                        fails++;
                        if (mism < 10)
                            $display("table row %0d: predictor %h vs typed %h", k, e,
                                     table_rows[k].exp);
                        mism++;
                    end
                    if (got) report_q.push_back(e);
                    void'(stim_b.pop_front());
                    void'(stim_last.pop_front());
                    k++;
                end
                else in_valid <= 0;
            end
        end
        do @(posedge clk); while (!(in_valid && in_ready));
        in_valid <= 0;
        stim_done = 1;
    end

    // receiver with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
            cyc <= 0;
            hold_count <= 0;
            hold_active <= 0;
            quiet_start <= 3000;
        end
        else
        begin
            cyc <= cyc + 1;
            if (cyc == 1500)
            begin
                hold_active <= 1;
                hold_count <= 300;
            end
            if (hold_active)
            begin
                out_ready <= 0;
                if (hold_count == 0) hold_active <= 0;
                else hold_count <= hold_count - 1;
            end
            else if (cyc >= quiet_start && cyc <= quiet_start + 400) out_ready <= 1;
            else out_ready <= ($urandom_range(0, 99) >= 22);
            if (out_valid && out_ready)
            begin
                if (report_q.size() == 0)
                begin
                    fails++;
                    if (mism < 10) $display("unexpected result %h", {sentence_kind,
                        checksum_ok, has_fix, time_valid, utc_second});
                    mism++;
                end
                else if (report_q[0] != {sentence_kind, checksum_ok, has_fix, time_valid,
                                          utc_second})
                begin
                    fails++;
                    if (mism < 10)
                        $display({"mismatch: exp kind %0d ck %0d fix %0d tv %0d s %0d,",
                                  " got kind %0d ck %0d fix %0d tv %0d s %0d"},
                                 report_q[0].kind, report_q[0].ck, report_q[0].fix,
                                 report_q[0].tv, report_q[0].secs, sentence_kind,
                                 checksum_ok, has_fix, time_valid, utc_second);
                    mism++;
                    void'(report_q.pop_front());
                end
                else void'(report_q.pop_front());
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (report_q.size() > 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fails == 0 && report_q.size() == 0)
            $display("nmea_gga_zda_sentence_parser verification clean");
        else
            $display("nmea_gga_zda_sentence_parser verification failed");
        $finish;
    end
endmodule
